/* rtl/core/phc_pkg.sv */
// ----------------------------------------------------------------------------
// phc_pkg: shared definitions for the half-plane polygon clipper
// Types, codes and default widths used by the front, the back and the top.
// ----------------------------------------------------------------------------
`default_nettype none

package phc_pkg;

	// Default coordinate width.
	localparam int COORD_BITS_DEF = 16;

	// Configuration register indexes.
	localparam logic [1:0] REG_LINE_AX = 2'd0;
	localparam logic [1:0] REG_LINE_AY = 2'd1;
	localparam logic [1:0] REG_LINE_BX = 2'd2;
	localparam logic [1:0] REG_LINE_BY = 2'd3;

	// Result kind codes on the output channel.
	localparam logic [1:0] KIND_KEEP  = 2'd0;
	localparam logic [1:0] KIND_CROSS = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;

	// Commands passed from the front to the back.
	typedef enum logic [1:0] {
		CMD_KEEP,
		CMD_CROSS,
		CMD_END
	} cmd_kind_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_MUL,
		F_CLS,
		F_EMIT
	} front_state_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_SIDE_P,
		B_SIDE_Q,
		B_DEN,
		B_CLAMP,
		B_SETUP,
		B_MUL,
		B_DIV,
		B_RND,
		B_OUT
	} back_state_t;

	// Queue status seen by the front.
	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

`default_nettype wire

/* rtl/core/phc_if.sv */
// ----------------------------------------------------------------------------
// phc_if: stream channels of the half-plane polygon clipper
// Vertex input channel and clipped point output channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface phc_in_if #(
	parameter int COORD_BITS = phc_pkg::COORD_BITS_DEF
) ();
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] in_x;
	logic signed [COORD_BITS-1:0] in_y;
	logic                         in_last;

	modport source (output valid, in_x, in_y, in_last, input ready);
	modport sink (input valid, in_x, in_y, in_last, output ready);
endinterface

interface phc_out_if #(
	parameter int COORD_BITS = phc_pkg::COORD_BITS_DEF
) ();
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] out_x;
	logic signed [COORD_BITS-1:0] out_y;
	logic [1:0]                   out_kind;
	logic                         run_last;

	modport source (output valid, out_x, out_y, out_kind, run_last, input ready);
	modport sink (input valid, out_x, out_y, out_kind, run_last, output ready);
endinterface

`default_nettype wire

/* rtl/core/phc_queue.sv */
// ----------------------------------------------------------------------------
// phc_queue: command queue between front and back
// Four-entry first-in first-out buffer of clip commands.
// ----------------------------------------------------------------------------
`default_nettype none

module phc_queue #(
	parameter int DATA_BITS = 67
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       push,
	input  wire [DATA_BITS-1:0]       push_data,
	input  wire                       pop,
	output logic [DATA_BITS-1:0]      head,
	output phc_pkg::queue_stat_t      stat
);
	import phc_pkg::*;

	localparam int DEPTH = 4;
	localparam int PW    = $clog2(DEPTH);

	logic [DATA_BITS-1:0] entry_q [DEPTH];
	logic [PW-1:0]        wr_ptr_q;
	logic [PW-1:0]        rd_ptr_q;
	logic [PW:0]          count_q;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_data;
	end

	assign head       = entry_q[rd_ptr_q];
	assign stat.full  = (count_q == (PW+1)'(DEPTH));
	assign stat.empty = (count_q == '0);
endmodule

`default_nettype wire

/* rtl/core/phc_front.sv */
// ----------------------------------------------------------------------------
// phc_front: vertex classification and command generation
// Takes vertices, tests them against the line, tracks the polygon and
// queues keep, crossing and end commands in output order.
// ----------------------------------------------------------------------------
`default_nettype none

module phc_front #(
	parameter int COORD_BITS = phc_pkg::COORD_BITS_DEF
) (
	input  wire                         clk,
	input  wire                         arst_n,
	phc_in_if.sink                      in_ch,
	input  wire signed [COORD_BITS-1:0] line_ax,
	input  wire signed [COORD_BITS-1:0] line_ay,
	input  wire signed [COORD_BITS-1:0] line_bx,
	input  wire signed [COORD_BITS-1:0] line_by,
	input  phc_pkg::queue_stat_t        q_stat,
	output logic                        q_push,
	output logic [4*COORD_BITS+2:0]     q_data
);
	import phc_pkg::*;

	localparam int C  = COORD_BITS;
	localparam int D  = C + 1;
	localparam int PW = 2 * C + 2;
	localparam int SW = 2 * C + 3;

	typedef struct packed {
		cmd_kind_t       kind;
		logic            run_last;
		logic [C-1:0]    px;
		logic [C-1:0]    py;
		logic [C-1:0]    qx;
		logic [C-1:0]    qy;
	} cmd_t;

	front_state_t state_q, state_d;

	logic signed [C-1:0]  cur_x_q, cur_y_q;
	logic                 cur_last_q;
	logic signed [PW-1:0] t1_s1, t2_s1;
	logic [C-1:0]         first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic                 first_in_q, prev_in_q, have_q;
	logic [C-1:0]         sp_x_q, sp_y_q, sc_x_q, sc_y_q, sf_x_q, sf_y_q;
	logic [4:0]           mask_q;

	logic signed [D-1:0]  dxa, dyb, dya, dxb;
	logic signed [SW-1:0] side;
	logic                 cin, fin_eff;
	logic [C-1:0]         fx_eff, fy_eff;
	logic [4:0]           mask_d, sel, rest;
	cmd_t                 cmd;

	// Terms of the side test for the current vertex.
	assign dxa = D'(cur_x_q) - D'(line_ax);
	assign dyb = D'(line_by) - D'(line_ay);
	assign dya = D'(cur_y_q) - D'(line_ay);
	assign dxb = D'(line_bx) - D'(line_ax);

	assign side    = SW'(t1_s1) - SW'(t2_s1);
	assign cin     = side[SW-1];
	assign fin_eff = have_q ? first_in_q : cin;
	assign fx_eff  = have_q ? first_x_q : cur_x_q;
	assign fy_eff  = have_q ? first_y_q : cur_y_q;

	// Which results this vertex causes, in emission order.
	always_comb begin
		mask_d[0] = have_q && prev_in_q;
		mask_d[1] = have_q && (prev_in_q != cin);
		mask_d[2] = cur_last_q && cin;
		mask_d[3] = cur_last_q && (cin != fin_eff);
		mask_d[4] = cur_last_q;
	end

	// Lowest pending result and those left after it.
	always_comb begin
		sel = '0;
		for (int i = 4; i >= 0; i--) begin
			if (mask_q[i]) sel = 5'b00001 << i;
		end
		rest = mask_q & ~sel;
	end

	// Build the command for the selected result.
	always_comb begin
		cmd          = '0;
		cmd.run_last = (rest == '0);
		case (1'b1)
			sel[0]: begin
				cmd.kind = CMD_KEEP;
				cmd.px   = sp_x_q;
				cmd.py   = sp_y_q;
			end
			sel[1]: begin
				cmd.kind = CMD_CROSS;
				cmd.px   = sp_x_q;
				cmd.py   = sp_y_q;
				cmd.qx   = sc_x_q;
				cmd.qy   = sc_y_q;
			end
			sel[2]: begin
				cmd.kind = CMD_KEEP;
				cmd.px   = sc_x_q;
				cmd.py   = sc_y_q;
			end
			sel[3]: begin
				cmd.kind = CMD_CROSS;
				cmd.px   = sc_x_q;
				cmd.py   = sc_y_q;
				cmd.qx   = sf_x_q;
				cmd.qy   = sf_y_q;
			end
			default: begin
				cmd.kind = CMD_END;
			end
		endcase
	end

	assign q_data      = cmd;
	assign q_push      = (state_q == F_EMIT) && !q_stat.full;
	assign in_ch.ready = (state_q == F_IDLE);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: if (in_ch.valid) state_d = F_MUL;
			F_MUL:  state_d = F_CLS;
			F_CLS:  state_d = (mask_d == '0) ? F_IDLE : F_EMIT;
			F_EMIT: if (!q_stat.full && rest == '0) state_d = F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= F_IDLE;
		else state_q <= state_d;
	end

	// Polygon tracking state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_x_q  <= '0;
			first_y_q  <= '0;
			first_in_q <= 1'b0;
			prev_x_q   <= '0;
			prev_y_q   <= '0;
			prev_in_q  <= 1'b0;
			have_q     <= 1'b0;
			mask_q     <= '0;
		end else begin
			if (state_q == F_CLS) begin
				mask_q <= mask_d;
				if (!have_q) begin
					first_x_q  <= cur_x_q;
					first_y_q  <= cur_y_q;
					first_in_q <= cin;
				end
				if (cur_last_q) begin
					have_q <= 1'b0;
				end else begin
					prev_x_q  <= cur_x_q;
					prev_y_q  <= cur_y_q;
					prev_in_q <= cin;
					have_q    <= 1'b1;
				end
			end else if (q_push) begin
				mask_q <= rest;
			end
		end
	end

	// Vertex capture, side products and operand snapshot.
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			cur_x_q    <= in_ch.in_x;
			cur_y_q    <= in_ch.in_y;
			cur_last_q <= in_ch.in_last;
		end
		if (state_q == F_MUL) begin
			t1_s1 <= PW'(dxa) * PW'(dyb);
			t2_s1 <= PW'(dya) * PW'(dxb);
		end
		if (state_q == F_CLS) begin
			sp_x_q <= prev_x_q;
			sp_y_q <= prev_y_q;
			sc_x_q <= cur_x_q;
			sc_y_q <= cur_y_q;
			sf_x_q <= fx_eff;
			sf_y_q <= fy_eff;
		end
	end
endmodule

`default_nettype wire

/* rtl/core/phc_back.sv */
// ----------------------------------------------------------------------------
// phc_back: command execution and crossing point arithmetic
// Sends kept vertices and end markers, and computes crossing points with
// a bit-serial multiplier and a restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none

module phc_back #(
	parameter int COORD_BITS = phc_pkg::COORD_BITS_DEF
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire signed [COORD_BITS-1:0] line_ax,
	input  wire signed [COORD_BITS-1:0] line_ay,
	input  wire signed [COORD_BITS-1:0] line_bx,
	input  wire signed [COORD_BITS-1:0] line_by,
	input  phc_pkg::queue_stat_t        q_stat,
	input  wire [4*COORD_BITS+2:0]      q_head,
	output logic                        q_pop,
	phc_out_if.source                   out_ch
);
	import phc_pkg::*;

	localparam int C  = COORD_BITS;
	localparam int D  = C + 1;
	localparam int PW = 2 * C + 2;
	localparam int SW = 2 * C + 3;
	localparam int W  = 2 * C + 4;
	localparam int NW = 2 * C + 3;
	localparam int AW = NW + C;
	localparam int CW = $clog2(C);

	typedef struct packed {
		cmd_kind_t       kind;
		logic            run_last;
		logic [C-1:0]    px;
		logic [C-1:0]    py;
		logic [C-1:0]    qx;
		logic [C-1:0]    qy;
	} cmd_t;

	back_state_t state_q, state_d;
	cmd_t        cmd;

	logic signed [PW-1:0] tp1_q, tp2_q;
	logic signed [SW-1:0] d1_q;
	logic signed [W-1:0]  den_q;
	logic [NW-1:0]        n_q;
	logic                 dz_q, axis_q, neg_q;
	logic [C-1:0]         mag_q, lo_q, quo_q, rx_q, ry_q;
	logic [AW-1:0]        acc_q;
	logic [NW-1:0]        rem_q;
	logic [CW-1:0]        cnt_q;

	logic                 ov_q;
	logic signed [C-1:0]  ox_q, oy_q;
	logic [1:0]           okind_q;
	logic                 olast_q;

	logic                 out_free;
	logic signed [C-1:0]  sx, sy;
	logic signed [D-1:0]  dxa, dyb, dya, dxb;
	logic signed [SW-1:0] diff;
	logic signed [W-1:0]  dd, nn, nclamp;
	logic signed [D-1:0]  dxy;
	logic [AW-1:0]        acc_d;
	logic [NW:0]          rem2, rem_sub;
	logic                 ge;
	logic [NW:0]          rem_x2;
	logic                 inc;
	logic [D-1:0]         rmag;
	logic signed [C+1:0]  off, pc, res;

	assign cmd      = q_head;
	assign out_free = !ov_q || out_ch.ready;

	// Side terms for the start point in B_SIDE_P, or the end point in B_SIDE_Q.
	assign sx   = (state_q == B_SIDE_P) ? $signed(cmd.px) : $signed(cmd.qx);
	assign sy   = (state_q == B_SIDE_P) ? $signed(cmd.py) : $signed(cmd.qy);
	assign dxa  = D'(sx) - D'(line_ax);
	assign dyb  = D'(line_by) - D'(line_ay);
	assign dya  = D'(sy) - D'(line_ay);
	assign dxb  = D'(line_bx) - D'(line_ax);
	assign diff = SW'(tp1_q) - SW'(tp2_q);

	// Normalize the denominator sign and clamp the ratio to [0,1].
	always_comb begin
		if (den_q[W-1]) begin
			dd = -den_q;
			nn = -W'(d1_q);
		end else begin
			dd = den_q;
			nn = W'(d1_q);
		end
		if (nn[W-1]) nclamp = '0;
		else if (nn > dd) nclamp = dd;
		else nclamp = nn;
	end

	// Edge delta on the current axis.
	assign dxy = axis_q ? (D'($signed(cmd.qy)) - D'($signed(cmd.py)))
	                    : (D'($signed(cmd.qx)) - D'($signed(cmd.px)));

	// One shift-add multiply step.
	assign acc_d = {acc_q[AW-2:0], 1'b0} + (mag_q[cnt_q] ? AW'(n_q) : '0);

	// One restoring divide step.
	assign rem2    = {rem_q, lo_q[C-1]};
	assign ge      = rem2 >= {1'b0, den_q[NW-1:0]};
	assign rem_sub = rem2 - {1'b0, den_q[NW-1:0]};

	// Round half toward positive infinity and add to the start point.
	always_comb begin
		rem_x2 = {rem_q, 1'b0};
		if (neg_q) inc = rem_x2 > {1'b0, den_q[NW-1:0]};
		else inc = rem_x2 >= {1'b0, den_q[NW-1:0]};
		rmag = {1'b0, quo_q} + D'(inc);
		if (dz_q) off = '0;
		else if (neg_q) off = -$signed({1'b0, rmag});
		else off = $signed({1'b0, rmag});
		pc  = axis_q ? (C+2)'($signed(cmd.py)) : (C+2)'($signed(cmd.px));
		res = pc + off;
	end

	assign q_pop = !q_stat.empty && out_free &&
	               ((state_q == B_IDLE && cmd.kind != CMD_CROSS) || state_q == B_OUT);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE:   if (!q_stat.empty && cmd.kind == CMD_CROSS) state_d = B_SIDE_P;
			B_SIDE_P: state_d = B_SIDE_Q;
			B_SIDE_Q: state_d = B_DEN;
			B_DEN:    state_d = B_CLAMP;
			B_CLAMP:  state_d = B_SETUP;
			B_SETUP:  state_d = B_MUL;
			B_MUL:    if (cnt_q == '0) state_d = B_DIV;
			B_DIV:    if (cnt_q == '0) state_d = B_RND;
			B_RND:    state_d = axis_q ? B_OUT : B_SETUP;
			B_OUT:    if (out_free) state_d = B_IDLE;
			default:  state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= B_IDLE;
		else state_q <= state_d;
	end

	// Datapath registers of the crossing computation.
	always_ff @(posedge clk) begin
		case (state_q) inside
			B_SIDE_P, B_SIDE_Q: begin
				tp1_q <= PW'(dxa) * PW'(dyb);
				tp2_q <= PW'(dya) * PW'(dxb);
				if (state_q == B_SIDE_Q) d1_q <= diff;
			end
			B_DEN: begin
				den_q <= W'(d1_q) - W'(diff);
			end
			B_CLAMP: begin
				dz_q   <= (den_q == '0);
				den_q  <= dd;
				n_q    <= nclamp[NW-1:0];
				axis_q <= 1'b0;
			end
			B_SETUP: begin
				neg_q <= dxy[D-1];
				mag_q <= dxy[D-1] ? C'(-dxy) : C'(dxy);
				acc_q <= '0;
				cnt_q <= CW'(C - 1);
			end
			B_MUL: begin
				acc_q <= acc_d;
				if (cnt_q == '0) begin
					rem_q <= acc_d[AW-1:C];
					lo_q  <= acc_d[C-1:0];
					quo_q <= '0;
					cnt_q <= CW'(C - 1);
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
			B_DIV: begin
				rem_q <= ge ? rem_sub[NW-1:0] : rem2[NW-1:0];
				lo_q  <= {lo_q[C-2:0], 1'b0};
				quo_q <= {quo_q[C-2:0], ge};
				cnt_q <= cnt_q - 1'b1;
			end
			B_RND: begin
				if (axis_q) ry_q <= res[C-1:0];
				else rx_q <= res[C-1:0];
				axis_q <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (q_pop) ov_q <= 1'b1;
		else if (out_ch.ready) ov_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			olast_q <= cmd.run_last;
			if (state_q == B_OUT) begin
				ox_q    <= rx_q;
				oy_q    <= ry_q;
				okind_q <= KIND_CROSS;
			end else if (cmd.kind == CMD_KEEP) begin
				ox_q    <= cmd.px;
				oy_q    <= cmd.py;
				okind_q <= KIND_KEEP;
			end else begin
				ox_q    <= '0;
				oy_q    <= '0;
				okind_q <= KIND_END;
			end
		end
	end

	assign out_ch.valid    = ov_q;
	assign out_ch.out_x    = ox_q;
	assign out_ch.out_y    = oy_q;
	assign out_ch.out_kind = okind_q;
	assign out_ch.run_last = olast_q;
endmodule

`default_nettype wire

/* rtl/core/polygon_halfplane_clip.sv */
// ----------------------------------------------------------------------------
// polygon_halfplane_clip: one Sutherland-Hodgman clipping stage
// Clips a streamed polygon against the half-plane left of a directed line.
// ----------------------------------------------------------------------------
// Vertices arrive on in_ch, one per beat, with in_last on the final vertex.
// Results leave on out_ch: kept vertices, crossing points and one end marker
// per polygon; run_last flags the last result caused by an input vertex.
// The line a to b is set through cfg_we, cfg_index and cfg_data. The user must
// set it only while the block is idle; the block itself does not enforce it.
// The front takes a vertex only in its idle state, forms the side products,
// classifies it and then queues each result it causes; it holds in_ch.ready
// low meanwhile and when the four-entry command queue is full. The back sends
// a kept vertex or an end marker straight from its idle state once its output
// register is free. A crossing point is computed with the serial multiply and
// restoring divide, run once per axis, for x and then for y.
// Reset clears the polygon state, empties the queue and restores the line
// to (0,0)-(1,0). When the receiver stalls, the output register holds its
// beat, the back waits, the queue fills and the front then stalls the input.
// ----------------------------------------------------------------------------
`default_nettype none

module polygon_halfplane_clip #(
	parameter int COORD_BITS = phc_pkg::COORD_BITS_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_we,
	input  wire [1:0]            cfg_index,
	input  wire [COORD_BITS-1:0] cfg_data,
	phc_in_if.sink               in_ch,
	phc_out_if.source            out_ch
);
	import phc_pkg::*;

	localparam int CMD_BITS = 4 * COORD_BITS + 3;

	logic signed [COORD_BITS-1:0] line_ax_q, line_ay_q, line_bx_q, line_by_q;
	queue_stat_t                  q_stat;
	logic                         q_push, q_pop;
	logic [CMD_BITS-1:0]          q_data, q_head;

	// Line registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_ax_q <= '0;
			line_ay_q <= '0;
			line_bx_q <= COORD_BITS'(1);
			line_by_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LINE_AX: line_ax_q <= cfg_data;
				REG_LINE_AY: line_ay_q <= cfg_data;
				REG_LINE_BX: line_bx_q <= cfg_data;
				REG_LINE_BY: line_by_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	phc_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.line_ax (line_ax_q),
		.line_ay (line_ay_q),
		.line_bx (line_bx_q),
		.line_by (line_by_q),
		.q_stat  (q_stat),
		.q_push  (q_push),
		.q_data  (q_data)
	);

	phc_queue #(.DATA_BITS(CMD_BITS)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.pop       (q_pop),
		.head      (q_head),
		.stat      (q_stat)
	);

	phc_back #(.COORD_BITS(COORD_BITS)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.line_ax (line_ax_q),
		.line_ay (line_ay_q),
		.line_bx (line_bx_q),
		.line_by (line_by_q),
		.q_stat  (q_stat),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.out_ch  (out_ch)
	);
endmodule

`default_nettype wire

/* rtl/core/phc_check.sv */
// ----------------------------------------------------------------------------
// phc_check: port-level checks of the half-plane polygon clipper
// Watches the output channel for well-formed results over time.
// ----------------------------------------------------------------------------
`default_nettype none

module phc_check #(
	parameter int COORD_BITS = phc_pkg::COORD_BITS_DEF
) (
	input wire                  clk,
	input wire                  arst_n,
	input wire                  out_valid,
	input wire                  out_ready,
	input wire [COORD_BITS-1:0] out_x,
	input wire [COORD_BITS-1:0] out_y,
	input wire [1:0]            out_kind,
	input wire                  run_last
);
	import phc_pkg::*;

	// Only the three defined kinds are ever sent.
	a_kind_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_kind == KIND_KEEP || out_kind == KIND_CROSS ||
		               out_kind == KIND_END))
		else $error("undefined result kind");

	// An end marker carries zero coordinates and closes the input's run.
	a_end_form: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_kind == KIND_END) |-> (out_x == '0 && out_y == '0 && run_last))
		else $error("malformed end marker");

	// A valid beat carries fully known values.
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown(out_valid) &&
		(out_valid -> !$isunknown({out_x, out_y, out_kind, run_last})))
		else $error("unknown value on result channel");

	// A stalled beat holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_x) && $stable(out_y) &&
		                               $stable(out_kind) && $stable(run_last)))
		else $error("stalled result changed");
endmodule

bind polygon_halfplane_clip phc_check #(.COORD_BITS(COORD_BITS)) u_phc_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_x     (out_ch.out_x),
	.out_y     (out_ch.out_y),
	.out_kind  (out_ch.out_kind),
	.run_last  (out_ch.run_last)
);

`default_nettype wire
